// ===== rtl/sgnm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgnm_pkg
// Shared types, constants and binary32 helpers for the sign-momentum step.
// ----------------------------------------------------------------------------
package sgnm_pkg;

   localparam int FP_LAT     = 5;                 // register stages in one float unit
   localparam int N_GROUPS   = 5;                 // chained unit groups in the back end
   localparam int PIPE_DEPTH = FP_LAT * N_GROUPS;
   localparam int Q_DEPTH    = 2;
   localparam int QPTR_W     = $clog2(Q_DEPTH);
   localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [31:0] ONE_F     = 32'h3F80_0000;
   localparam logic [31:0] ZERO_F    = 32'h0000_0000;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

   localparam logic [1:0] REG_LR = 2'd0;
   localparam logic [1:0] REG_B1 = 2'd1;
   localparam logic [1:0] REG_B2 = 2'd2;
   localparam logic [1:0] REG_WD = 2'd3;

   typedef struct packed {
      logic [31:0] param;
      logic [31:0] momentum;
      logic [31:0] gradient;
      logic        decay_on;
   } item_type;

   typedef struct packed {
      logic nan;
      logic inf;
   } spec_type;

   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd28;
      found = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(27 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // e == 0 means subnormal scale; the hidden bit then decides the field
   function automatic logic [31:0] round_pack(input logic        sign,
                                              input logic [9:0]  e,
                                              input logic [23:0] m,
                                              input logic        g,
                                              input logic        st);
      logic        up;
      logic [24:0] m25;
      logic [23:0] mf;
      logic [9:0]  e2;
      logic [7:0]  fe;
      up  = g & (st | m[0]);
      m25 = {1'b0, m} + {24'd0, up};
      if (m25[24]) begin
         mf = m25[24:1];
         e2 = e + 10'd1;
      end else begin
         mf = m25[23:0];
         e2 = e;
      end
      fe = (e2 == 10'd0) ? {7'd0, mf[23]} : e2[7:0];
      if (e2 >= 10'd255) begin
         return {sign, 8'hFF, 23'd0};
      end
      return {sign, fe, mf[22:0]};
   endfunction

endpackage

// ===== rtl/sign_momentum_optimizer_step.sv =====
// ----------------------------------------------------------------------------
// sign_momentum_optimizer_step
// Lion-style sign-momentum update of one binary32 parameter element per request.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled and returns one
// result per request, in order. A request accepted into the two-entry intake
// queue is popped, when the pipeline is free to advance, into five chained
// groups of 5-stage float units (blend terms, gradient products, sums,
// p - lr*sign, minus decay) and lands in the result register after the last
// group. All arithmetic is binary32 with round to nearest even and subnormals
// kept; any NaN result is 0x7FC00000.
// Registers (byte address): learning_rate 0x0, beta_one 0x4, beta_two 0x8,
// decay_rate 0xC; write them only while no request is in flight.
module sign_momentum_optimizer_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,    // param_in, momentum_in, gradient_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // param_out, momentum_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sgnm_pkg::*;

   logic [31:0] lr_ff, lr_in, b1_ff, b1_in, b2_ff, b2_in, wd_ff, wd_in;
   logic        csr_wr;
   logic        q_valid, q_pop;
   item_type    q_item;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      lr_in = lr_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      wd_in = wd_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_LR:  lr_in = csr_pwdata;
            REG_B1:  b1_in = csr_pwdata;
            REG_B2:  b2_in = csr_pwdata;
            REG_WD:  wd_in = csr_pwdata;
            default: lr_in = lr_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_LR:  csr_prdata = lr_ff;
         REG_B1:  csr_prdata = b1_ff;
         REG_B2:  csr_prdata = b2_ff;
         REG_WD:  csr_prdata = wd_ff;
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= 32'h38D1_B717;
         b1_ff <= 32'h3F66_6666;
         b2_ff <= 32'h3F7D_70A4;
         wd_ff <= 32'h0000_0000;
      end else begin
         lr_ff <= lr_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         wd_ff <= wd_in;
      end
   end

   sgnm_front u_front (
      .clock,
      .reset,
      .decay_rate (wd_ff),
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .q_valid,
      .q_item,
      .q_pop
   );

   sgnm_back u_back (
      .clock,
      .reset,
      .learning_rate (lr_ff),
      .beta_one      (b1_ff),
      .beta_two      (b2_ff),
      .decay_rate    (wd_ff),
      .q_valid,
      .q_item,
      .q_pop,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata
   );

endmodule

// ===== rtl/sgnm_front.sv =====
// ----------------------------------------------------------------------------
// sgnm_front
// Request intake: tags each request with the decay gate and queues it.
// ----------------------------------------------------------------------------
module sgnm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       decay_rate,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [95:0]       req_tdata,   // param_in, momentum_in, gradient_in
   output logic              q_valid,
   output sgnm_pkg::item_type q_item,
   input  logic              q_pop
);
   import sgnm_pkg::*;

   item_type            mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push;
   logic                decay_on;
   item_type            new_item;

   // decay applies only when wd compares greater than +0
   assign decay_on = !decay_rate[31] && (decay_rate[30:0] != 31'd0) && !is_nan(decay_rate);

   always_comb begin
      new_item.param    = req_tdata[31:0];
      new_item.momentum = req_tdata[63:32];
      new_item.gradient = req_tdata[95:64];
      new_item.decay_on = decay_on;
   end

   assign req_tready = (cnt_ff != QCNT_W'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(Q_DEPTH)) else $error("queue count overflow");
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == QCNT_W'(Q_DEPTH) |-> !req_tready) else $error("request taken while full");

endmodule

// ===== rtl/sgnm_fmul.sv =====
// ----------------------------------------------------------------------------
// sgnm_fmul
// Pipelined binary32 multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module sgnm_fmul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import sgnm_pkg::*;

   // stage 1: mantissa product
   logic [47:0]        p1_ff, p1_in;
   logic signed [10:0] er1_ff, er1_in;
   logic               sg1_ff, sg1_in;
   spec_type           sp1_ff, sp1_in;
   logic               z1_ff, z1_in;
   // stage 2: shift plan
   logic [47:0]        p2_ff;
   logic               left2_ff, left2_in;
   logic [5:0]         amt2_ff, amt2_in;
   logic [9:0]         e2_ff, e2_in;
   logic               sg2_ff;
   spec_type           sp2_ff;
   logic               z2_ff;
   // stage 3: shifted mantissa
   logic [47:0]        q3_ff, q3_in;
   logic               stx3_ff, stx3_in;
   logic [9:0]         e3_ff;
   logic               sg3_ff;
   spec_type           sp3_ff;
   logic               z3_ff;
   // stage 4/5: packed result
   logic [31:0]        y4_ff, y4_in;
   logic [31:0]        y5_ff;

   always_comb begin
      logic [7:0] ea, eb;
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      p1_in  = {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
      er1_in = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
      sg1_in = a[31] ^ b[31];
      z1_in  = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
      sp1_in.inf = is_inf(a) || is_inf(b);
      sp1_in.nan = is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 31'd0)
                   || (is_inf(b) && a[30:0] == 31'd0);
   end

   always_comb begin
      logic [5:0]         lz;
      logic signed [10:0] diff, k, r;
      lz   = lzc48(p1_ff);
      diff = er1_ff - $signed({5'd0, lz});
      k    = er1_ff - 11'sd1;
      r    = 11'sd1 - er1_ff;
      if (diff >= 11'sd1) begin
         left2_in = 1'b1;
         amt2_in  = lz;
         e2_in    = diff[9:0];
      end else if (k >= 11'sd0) begin
         left2_in = 1'b1;
         amt2_in  = k[5:0];
         e2_in    = 10'd0;
      end else begin
         // result sits below the subnormal scale
         left2_in = 1'b0;
         amt2_in  = (r > 11'sd48) ? 6'd48 : r[5:0];
         e2_in    = 10'd0;
      end
   end

   always_comb begin
      logic [95:0] ext;
      ext = {p2_ff, 48'd0} >> amt2_ff;
      if (left2_ff) begin
         q3_in   = p2_ff << amt2_ff;
         stx3_in = 1'b0;
      end else begin
         q3_in   = ext[95:48];
         stx3_in = |ext[47:0];
      end
   end

   always_comb begin
      if (sp3_ff.nan) begin
         y4_in = CANON_NAN;
      end else if (sp3_ff.inf) begin
         y4_in = {sg3_ff, 8'hFF, 23'd0};
      end else if (z3_ff) begin
         y4_in = {sg3_ff, 31'd0};
      end else begin
         y4_in = round_pack(sg3_ff, e3_ff, q3_ff[47:24], q3_ff[23],
                            (|q3_ff[22:0]) | stx3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= p1_in;
         er1_ff   <= er1_in;
         sg1_ff   <= sg1_in;
         sp1_ff   <= sp1_in;
         z1_ff    <= z1_in;
         p2_ff    <= p1_ff;
         left2_ff <= left2_in;
         amt2_ff  <= amt2_in;
         e2_ff    <= e2_in;
         sg2_ff   <= sg1_ff;
         sp2_ff   <= sp1_ff;
         z2_ff    <= z1_ff;
         q3_ff    <= q3_in;
         stx3_ff  <= stx3_in;
         e3_ff    <= e2_ff;
         sg3_ff   <= sg2_ff;
         sp3_ff   <= sp2_ff;
         z3_ff    <= z2_ff;
         y4_ff    <= y4_in;
         y5_ff    <= y4_ff;
      end
   end

   assign y = y5_ff;

endmodule

// ===== rtl/sgnm_fadd.sv =====
// ----------------------------------------------------------------------------
// sgnm_fadd
// Pipelined binary32 adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module sgnm_fadd (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import sgnm_pkg::*;

   // stage 1: order by magnitude
   logic [23:0] ml1_ff, ml1_in, ms1_ff, ms1_in;
   logic [7:0]  el1_ff, el1_in, d1_ff, d1_in;
   logic        sub1_ff, sub1_in, sg1_ff, sg1_in;
   spec_type    sp1_ff, sp1_in;
   // stage 2: aligned operands
   logic [26:0] ml2_ff, mb2_ff, mb2_in;
   logic [7:0]  el2_ff;
   logic        sub2_ff, sg2_ff;
   spec_type    sp2_ff;
   // stage 3: sum
   logic [27:0] s3_ff, s3_in;
   logic [7:0]  el3_ff;
   logic        sub3_ff, sg3_ff;
   spec_type    sp3_ff;
   // stage 4: normalize plan
   logic [27:0] s4_ff;
   logic [4:0]  sh4_ff, sh4_in;
   logic [9:0]  e4_ff, e4_in;
   logic        z4_ff, z4_in, sub4_ff, sg4_ff;
   spec_type    sp4_ff;
   // stage 5: packed result
   logic [31:0] y5_ff, y5_in;

   always_comb begin
      logic [31:0] l, s;
      logic [7:0]  es;
      logic        swap;
      swap   = a[30:0] < b[30:0];
      l      = swap ? b : a;
      s      = swap ? a : b;
      el1_in = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
      es     = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
      d1_in  = el1_in - es;
      ml1_in = {(l[30:23] != 8'd0), l[22:0]};
      ms1_in = {(s[30:23] != 8'd0), s[22:0]};
      sub1_in = a[31] ^ b[31];
      sp1_in.nan = is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]));
      sp1_in.inf = is_inf(a) || is_inf(b);
      if (is_inf(a)) begin
         sg1_in = a[31];
      end else if (is_inf(b)) begin
         sg1_in = b[31];
      end else begin
         sg1_in = l[31];
      end
   end

   always_comb begin
      logic [53:0] ext;
      logic [4:0]  dd;
      dd     = (d1_ff > 8'd27) ? 5'd27 : d1_ff[4:0];
      ext    = {ms1_ff, 3'd0, 27'd0} >> dd;
      mb2_in = {ext[53:28], ext[27] | (|ext[26:0])};
   end

   assign s3_in = sub2_ff ? ({1'b0, ml2_ff} - {1'b0, mb2_ff})
                          : ({1'b0, ml2_ff} + {1'b0, mb2_ff});

   always_comb begin
      logic [4:0] lz;
      lz    = lzc28(s3_ff);
      z4_in = (s3_ff == 28'd0);
      if ({3'd0, lz} <= el3_ff) begin
         sh4_in = lz;
         e4_in  = {2'd0, el3_ff} + 10'd1 - {5'd0, lz};
      end else begin
         sh4_in = el3_ff[4:0];
         e4_in  = 10'd0;
      end
   end

   always_comb begin
      logic [27:0] t;
      t = s4_ff << sh4_ff;
      if (sp4_ff.nan) begin
         y5_in = CANON_NAN;
      end else if (sp4_ff.inf) begin
         y5_in = {sg4_ff, 8'hFF, 23'd0};
      end else if (z4_ff) begin
         // exact cancellation gives +0
         y5_in = {sg4_ff & !sub4_ff, 31'd0};
      end else begin
         y5_in = round_pack(sg4_ff, e4_ff, t[27:4], t[3], |t[2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ml1_ff  <= ml1_in;
         ms1_ff  <= ms1_in;
         el1_ff  <= el1_in;
         d1_ff   <= d1_in;
         sub1_ff <= sub1_in;
         sg1_ff  <= sg1_in;
         sp1_ff  <= sp1_in;
         ml2_ff  <= {ml1_ff, 3'd0};
         mb2_ff  <= mb2_in;
         el2_ff  <= el1_ff;
         sub2_ff <= sub1_ff;
         sg2_ff  <= sg1_ff;
         sp2_ff  <= sp1_ff;
         s3_ff   <= s3_in;
         el3_ff  <= el2_ff;
         sub3_ff <= sub2_ff;
         sg3_ff  <= sg2_ff;
         sp3_ff  <= sp2_ff;
         s4_ff   <= s3_ff;
         sh4_ff  <= sh4_in;
         e4_ff   <= e4_in;
         z4_ff   <= z4_in;
         sub4_ff <= sub3_ff;
         sg4_ff  <= sg3_ff;
         sp4_ff  <= sp3_ff;
         y5_ff   <= y5_in;
      end
   end

   assign y = y5_ff;

endmodule

// ===== rtl/sgnm_back.sv =====
// ----------------------------------------------------------------------------
// sgnm_back
// Update pipeline: five chained groups of float units and the result register.
// ----------------------------------------------------------------------------
module sgnm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        learning_rate,
   input  logic [31:0]        beta_one,
   input  logic [31:0]        beta_two,
   input  logic [31:0]        decay_rate,
   input  logic               q_valid,
   input  sgnm_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata    // param_out, momentum_out
);
   import sgnm_pkg::*;

   typedef struct packed {
      logic [31:0] par;
      logic [31:0] grad;
      logic        dec_on;
   } a_side_type;

   typedef struct packed {
      logic [31:0] par;
      logic        dec_on;
      logic [31:0] t1;
      logic [31:0] s1;
   } b_side_type;

   typedef struct packed {
      logic [31:0] par;
      logic [31:0] dec;
   } c_side_type;

   typedef struct packed {
      logic [31:0] nm;
      logic [31:0] dec;
   } d_side_type;

   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   a_side_type            a_ff [FP_LAT];
   a_side_type            a_in;
   b_side_type            b_ff [FP_LAT];
   b_side_type            b_in;
   c_side_type            c_ff [FP_LAT];
   c_side_type            c_in;
   d_side_type            d_ff [FP_LAT];
   d_side_type            d_in;
   logic [31:0]           e_ff [FP_LAT];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_data_ff, rsp_data_in;

   logic [31:0] t1, s1, lw, t2, s2, t3, s3, dec, blend, nm, step, np1, np;

   assign en    = !rsp_valid_ff || rsp_tready;
   assign q_pop = en && q_valid;

   // group a: products with momentum, lr*wd and the one-minus terms
   sgnm_fmul u_mul_t1 (.clock, .en, .a(beta_one), .b(q_item.momentum), .y(t1));
   sgnm_fmul u_mul_s1 (.clock, .en, .a(beta_two), .b(q_item.momentum), .y(s1));
   sgnm_fmul u_mul_lw (.clock, .en, .a(learning_rate), .b(decay_rate), .y(lw));
   sgnm_fadd u_add_t2 (.clock, .en, .a(ONE_F), .b(beta_one ^ SIGN_MASK), .y(t2));
   sgnm_fadd u_add_s2 (.clock, .en, .a(ONE_F), .b(beta_two ^ SIGN_MASK), .y(s2));

   // group b: gradient products and the decay product
   sgnm_fmul u_mul_t3  (.clock, .en, .a(t2), .b(a_ff[FP_LAT-1].grad), .y(t3));
   sgnm_fmul u_mul_s3  (.clock, .en, .a(s2), .b(a_ff[FP_LAT-1].grad), .y(s3));
   sgnm_fmul u_mul_dec (.clock, .en, .a(lw), .b(a_ff[FP_LAT-1].par), .y(dec));

   // group c: direction blend and new momentum
   sgnm_fadd u_add_blend (.clock, .en, .a(b_ff[FP_LAT-1].t1), .b(t3), .y(blend));
   sgnm_fadd u_add_nm    (.clock, .en, .a(b_ff[FP_LAT-1].s1), .b(s3), .y(nm));

   // lr times the sign of the blend, which is -1, 0 or +1
   always_comb begin
      if (is_nan(blend) || blend[30:0] == 31'd0) begin
         step = (is_nan(learning_rate) || is_inf(learning_rate)) ? CANON_NAN
                                                                 : {learning_rate[31], 31'd0};
      end else if (blend[31]) begin
         step = learning_rate ^ SIGN_MASK;
      end else begin
         step = learning_rate;
      end
   end

   // group d: p - step
   sgnm_fadd u_add_np1 (.clock, .en, .a(c_ff[FP_LAT-1].par), .b(step ^ SIGN_MASK), .y(np1));

   // group e: minus decay
   sgnm_fadd u_add_np (.clock, .en, .a(np1), .b(d_ff[FP_LAT-1].dec ^ SIGN_MASK), .y(np));

   always_comb begin
      a_in.par    = q_item.param;
      a_in.grad   = q_item.gradient;
      a_in.dec_on = q_item.decay_on;
      b_in.par    = a_ff[FP_LAT-1].par;
      b_in.dec_on = a_ff[FP_LAT-1].dec_on;
      b_in.t1     = t1;
      b_in.s1     = s1;
      c_in.par    = b_ff[FP_LAT-1].par;
      c_in.dec    = b_ff[FP_LAT-1].dec_on ? dec : ZERO_F;
      d_in.nm     = nm;
      d_in.dec    = c_ff[FP_LAT-1].dec;
      vld_in      = {vld_ff[PIPE_DEPTH-2:0], q_valid};
      rsp_valid_in = en ? vld_ff[PIPE_DEPTH-1] : rsp_valid_ff;
      rsp_data_in  = en ? {e_ff[FP_LAT-1], np} : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (en) begin
         a_ff[0] <= a_in;
         b_ff[0] <= b_in;
         c_ff[0] <= c_in;
         d_ff[0] <= d_in;
         e_ff[0] <= d_ff[FP_LAT-1].nm;
         for (int i = 1; i < FP_LAT; i++) begin
            a_ff[i] <= a_ff[i-1];
            b_ff[i] <= b_ff[i-1];
            c_ff[i] <= c_ff[i-1];
            d_ff[i] <= d_ff[i-1];
            e_ff[i] <= e_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff)) else $error("pipeline moved while stalled");
   a_land: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[PIPE_DEPTH-1] |=> rsp_valid_ff) else $error("result lost at output");
   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> vld_ff[0]) else $error("popped request not in pipeline");

endmodule
